>>> rtl/core/psc_pkg.sv
// Package for the pressure sensor compensation block: sequencer states, register
// indexes, formula constants and small sign helpers.
// No dependencies; used by every module in rtl/core.
package psc_pkg;

   localparam int DATA_W = 64;
   localparam int CNT_W  = 6;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

   // Configuration register indexes.
   localparam logic [1:0] CSR_TEMP_CAL       = 2'd0;
   localparam logic [1:0] CSR_PRESS_CAL_LOW  = 2'd1;
   localparam logic [1:0] CSR_PRESS_CAL_HIGH = 2'd2;
   localparam logic [1:0] CSR_PRESS_CAL_NINE = 2'd3;

   // Result kinds.
   localparam logic KIND_TEMP  = 1'b0;
   localparam logic KIND_PRESS = 1'b1;

   // Formula constants.
   localparam logic [63:0] PRESS_T_OFFSET = 64'd128000;
   localparam logic [63:0] PRESS_RAW_FULL = 64'd1048576;
   localparam logic [63:0] PRESS_SCALE    = 64'd3125;
   localparam logic [31:0] TEMP_ROUND     = 32'd128;
   localparam logic [63:0] PRESS_BIAS     = 64'h0000_8000_0000_0000;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_T_A,
      ST_T_D,
      ST_T_E,
      ST_T_FIN,
      ST_P_INIT,
      ST_P_SQ,
      ST_P_V2,
      ST_P_V5,
      ST_P_U,
      ST_P_W,
      ST_P_P1,
      ST_P_CHK,
      ST_P_N,
      ST_P_DIV,
      ST_P_Q1,
      ST_P_Q2,
      ST_P_R,
      ST_P_FIN,
      ST_P_ZERO
   } state_type;

   // Sign-extend a 16-bit calibration word to 64 bits.
   function automatic logic [63:0] sx16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   // Arithmetic right shift on 64 bits.
   function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
      return $unsigned($signed(x) >>> n);
   endfunction

   // Arithmetic right shift on 32 bits.
   function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
      return $unsigned($signed(x) >>> n);
   endfunction

endpackage

>>> rtl/core/pressure_sensor_compensation_64bit.sv
// Top level of the pressure sensor compensation block: sequencer, working
// registers and calibration registers. Depends on psc_pkg, psc_mul, psc_div.
//
//   channel  | ports                                        | direction
//   request  | req_valid req_ready req_op req_raw_sample    | in
//   response | rsp_valid rsp_ready rsp_kind rsp_temperature_centi
//            | rsp_pressure_q24_8 rsp_div_zero              | out
//   config   | csr_wr_en csr_index csr_wdata                | in
//
// Every multiply runs bit-serially in psc_mul and the division in psc_div, one
// unit at a time under the sequencer; a pressure request whose divisor is zero
// skips the division and the steps after it.
// One request is in flight at a time; req_ready is high only when idle.
// A finished result waits in the response register; the next result cannot
// retire until it is taken. Synchronous reset clears control and fine temperature.
module pressure_sensor_compensation_64bit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [19:0] req_raw_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [31:0] rsp_temperature_centi,
   output logic [31:0] rsp_pressure_q24_8,
   output logic        rsp_div_zero,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import psc_pkg::*;

   state_type state_ff, state_in;

   logic [47:0] temp_cal_ff;
   logic [63:0] press_cal_low_ff;
   logic [63:0] press_cal_high_ff;
   logic [15:0] press_cal_nine_ff;

   logic [19:0] raw_ff, raw_in;
   logic [31:0] fine_ff, fine_in;
   logic [63:0] ra_ff, ra_in;
   logic [63:0] rb_ff, rb_in;
   logic [63:0] rc_ff, rc_in;
   logic [63:0] rd_ff, rd_in;
   logic        pend_ff, pend_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_temp_ff, rsp_temp_in;
   logic [31:0] rsp_press_ff, rsp_press_in;
   logic        rsp_dz_ff, rsp_dz_in;

   logic        mul_start, mul_done;
   logic [63:0] mul_a, mul_b, mul_p;
   logic        div_start, div_done;
   logic [63:0] div_q;
   logic        unit_done;
   logic        out_free;

   logic [15:0] t1, t2, t3;
   logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8;
   logic [31:0] temp_a, temp_d, temp_x;
   logic [63:0] p_final;

   assign t1 = temp_cal_ff[15:0];
   assign t2 = temp_cal_ff[31:16];
   assign t3 = temp_cal_ff[47:32];
   assign p1 = press_cal_low_ff[15:0];
   assign p2 = press_cal_low_ff[31:16];
   assign p3 = press_cal_low_ff[47:32];
   assign p4 = press_cal_low_ff[63:48];
   assign p5 = press_cal_high_ff[15:0];
   assign p6 = press_cal_high_ff[31:16];
   assign p7 = press_cal_high_ff[47:32];
   assign p8 = press_cal_high_ff[63:48];

   assign temp_a  = {15'b0, raw_ff[19:3]} - {15'b0, t1, 1'b0};
   assign temp_d  = {16'b0, raw_ff[19:4]} - {16'b0, t1};
   assign temp_x  = (fine_ff << 2) + fine_ff + TEMP_ROUND;
   assign p_final = asr64(rb_ff + rc_ff + rd_ff, 8) + (sx16(p7) << 4);

   assign unit_done = mul_done | div_done;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   psc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   psc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rb_ff),
      .divisor  (ra_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_op == KIND_PRESS) ? ST_P_INIT : ST_T_A;
            end
         end
         ST_T_A:    if (mul_done) state_in = ST_T_D;
         ST_T_D:    if (mul_done) state_in = ST_T_E;
         ST_T_E:    if (mul_done) state_in = ST_T_FIN;
         ST_P_INIT: state_in = ST_P_SQ;
         ST_P_SQ:   if (mul_done) state_in = ST_P_V2;
         ST_P_V2:   if (mul_done) state_in = ST_P_V5;
         ST_P_V5:   if (mul_done) state_in = ST_P_U;
         ST_P_U:    if (mul_done) state_in = ST_P_W;
         ST_P_W:    if (mul_done) state_in = ST_P_P1;
         ST_P_P1:   if (mul_done) state_in = ST_P_CHK;
         ST_P_CHK:  state_in = (ra_ff == '0) ? ST_P_ZERO : ST_P_N;
         ST_P_N:    if (mul_done) state_in = ST_P_DIV;
         ST_P_DIV:  if (div_done) state_in = ST_P_Q1;
         ST_P_Q1:   if (mul_done) state_in = ST_P_Q2;
         ST_P_Q2:   if (mul_done) state_in = ST_P_R;
         ST_P_R:    if (mul_done) state_in = ST_P_FIN;
         ST_T_FIN, ST_P_FIN, ST_P_ZERO: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and unit control for each sequencer step.
   always_comb begin
      raw_in       = raw_ff;
      fine_in      = fine_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      rc_in        = rc_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_temp_in  = rsp_temp_ff;
      rsp_press_in = rsp_press_ff;
      rsp_dz_in    = rsp_dz_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            raw_in    = req_raw_sample;
         end
         ST_T_A: begin
            mul_a = {{32{temp_a[31]}}, temp_a};
            mul_b = sx16(t2);
            if (mul_done) rc_in = {32'b0, asr32(mul_p[31:0], 11)};
         end
         ST_T_D: begin
            mul_a = {32'b0, temp_d};
            mul_b = {32'b0, temp_d};
            if (mul_done) rb_in = {32'b0, asr32(mul_p[31:0], 12)};
         end
         ST_T_E: begin
            mul_a = rb_ff;
            mul_b = sx16(t3);
            if (mul_done) fine_in = rc_ff[31:0] + asr32(mul_p[31:0], 14);
         end
         ST_P_INIT: begin
            ra_in = {{32{fine_ff[31]}}, fine_ff} - PRESS_T_OFFSET;
         end
         ST_P_SQ: begin
            mul_a = ra_ff;
            mul_b = ra_ff;
            if (mul_done) rb_in = mul_p;
         end
         ST_P_V2: begin
            mul_a = rb_ff;
            mul_b = sx16(p6);
            if (mul_done) rc_in = mul_p;
         end
         ST_P_V5: begin
            mul_a = ra_ff;
            mul_b = sx16(p5);
            if (mul_done) rc_in = rc_ff + (mul_p << 17) + (sx16(p4) << 35);
         end
         ST_P_U: begin
            mul_a = rb_ff;
            mul_b = sx16(p3);
            if (mul_done) rb_in = asr64(mul_p, 8);
         end
         ST_P_W: begin
            mul_a = ra_ff;
            mul_b = sx16(p2);
            if (mul_done) ra_in = rb_ff + (mul_p << 12);
         end
         ST_P_P1: begin
            mul_a = PRESS_BIAS + ra_ff;
            mul_b = {48'b0, p1};
            if (mul_done) ra_in = asr64(mul_p, 33);
         end
         ST_P_CHK: begin
         end
         ST_P_N: begin
            mul_a = ((PRESS_RAW_FULL - {44'b0, raw_ff}) << 31) - rc_ff;
            mul_b = PRESS_SCALE;
            if (mul_done) rb_in = mul_p;
         end
         ST_P_DIV: begin
            div_start = !pend_ff && !div_done;
            if (div_done) rb_in = div_q;
         end
         ST_P_Q1: begin
            mul_a = sx16(press_cal_nine_ff);
            mul_b = asr64(rb_ff, 13);
            if (mul_done) rc_in = mul_p;
         end
         ST_P_Q2: begin
            mul_a = rc_ff;
            mul_b = asr64(rb_ff, 13);
            if (mul_done) rc_in = asr64(mul_p, 25);
         end
         ST_P_R: begin
            mul_a = sx16(p8);
            mul_b = rb_ff;
            if (mul_done) rd_in = asr64(mul_p, 19);
         end
         ST_T_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_TEMP;
               rsp_temp_in  = asr32(temp_x, 8);
               rsp_press_in = '0;
               rsp_dz_in    = 1'b0;
            end
         end
         ST_P_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_PRESS;
               rsp_temp_in  = '0;
               rsp_press_in = p_final[31:0];
               rsp_dz_in    = 1'b0;
            end
         end
         ST_P_ZERO: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_PRESS;
               rsp_temp_in  = '0;
               rsp_press_in = '0;
               rsp_dz_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // Multiply steps launch the unit once and wait for its done pulse.
      unique case (state_ff)
         ST_T_A, ST_T_D, ST_T_E, ST_P_SQ, ST_P_V2, ST_P_V5, ST_P_U, ST_P_W,
         ST_P_P1, ST_P_N, ST_P_Q1, ST_P_Q2, ST_P_R: begin
            mul_start = !pend_ff && !mul_done;
         end
         default: begin
         end
      endcase

      pend_in = (mul_start || div_start) || (pend_ff && !unit_done);
   end

   // Sequencer, working and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fine_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         fine_ff      <= fine_in;
      end
      raw_ff       <= raw_in;
      ra_ff        <= ra_in;
      rb_ff        <= rb_in;
      rc_ff        <= rc_in;
      rd_ff        <= rd_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_temp_ff  <= rsp_temp_in;
      rsp_press_ff <= rsp_press_in;
      rsp_dz_ff    <= rsp_dz_in;
   end

   // Calibration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff       <= '0;
         press_cal_low_ff  <= '0;
         press_cal_high_ff <= '0;
         press_cal_nine_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TEMP_CAL:       temp_cal_ff       <= csr_wdata[47:0];
            CSR_PRESS_CAL_LOW:  press_cal_low_ff  <= csr_wdata;
            CSR_PRESS_CAL_HIGH: press_cal_high_ff <= csr_wdata;
            CSR_PRESS_CAL_NINE: press_cal_nine_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = rsp_kind_ff;
   assign rsp_temperature_centi = rsp_temp_ff;
   assign rsp_pressure_q24_8    = rsp_press_ff;
   assign rsp_div_zero          = rsp_dz_ff;

endmodule

>>> rtl/core/psc_mul.sv
// Bit-serial 64 x 64 multiplier keeping the low 64 product bits.
// Depends on psc_pkg.
module psc_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [psc_pkg::DATA_W-1:0] op_a,
   input  logic [psc_pkg::DATA_W-1:0] op_b,
   output logic                      done,
   output logic [psc_pkg::DATA_W-1:0] product
);
   import psc_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] acc_ff, acc_in;

   // One multiplier bit per cycle: add the shifted multiplicand when the bit is set.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = {a_ff[DATA_W-2:0], 1'b0};
         b_in   = {1'b0, b_ff[DATA_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

>>> rtl/core/psc_div.sv
// Bit-serial signed 64-bit divider, restoring, one quotient bit per cycle.
// Depends on psc_pkg. The divisor must be nonzero.
module psc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [psc_pkg::DATA_W-1:0] dividend,
   input  logic [psc_pkg::DATA_W-1:0] divisor,
   output logic                      done,
   output logic [psc_pkg::DATA_W-1:0] quotient
);
   import psc_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;
   logic              fits;

   assign trial = {rem_ff, quo_ff[DATA_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   // Work on magnitudes; the sign is applied to the finished quotient.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
         quo_in  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         dvs_in  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

>>> sim/tb.sv
// Testbench for the pressure sensor compensation block: a directed table with fixed
// expectations, then requests checked against an in-bench model of the compensation formulas.
// Depends on psc_pkg and pressure_sensor_compensation_64bit.
module tb;
   import psc_pkg::*;

   typedef struct {
      logic        kind;
      logic [31:0] temperature_centi;
      logic [31:0] pressure_q24_8;
      logic        div_zero;
   } reading_type;

   typedef struct {
      logic        op;
      logic [19:0] raw;
      logic        typed;
      reading_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_op;
   logic [19:0] req_raw_sample;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_kind;
   logic [31:0] rsp_temperature_centi;
   logic [31:0] rsp_pressure_q24_8;
   logic        rsp_div_zero;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   // Model copy of the calibration registers and the fine temperature.
   logic [47:0] cal_temp;
   logic [63:0] cal_press_lo;
   logic [63:0] cal_press_hi;
   logic [15:0] cal_press_p9;
   logic [31:0] fine_temp;

   reading_type  pending_readings[$];
   stim_row_type directed_rows[$];
   int           errors;
   int           long_hold_req;

   pressure_sensor_compensation_64bit dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #80000000;
      $display("FAIL");
      $finish;
   end

   // Arithmetic right shifts done through signed temporaries.
   function automatic logic [31:0] shr32(input logic [31:0] x, input int n);
      logic signed [31:0] s;
      s = x;
      return s >>> n;
   endfunction

   function automatic logic [63:0] shr64(input logic [63:0] x, input int n);
      logic signed [63:0] s;
      s = x;
      return s >>> n;
   endfunction

   function automatic logic [63:0] widen16(input logic [15:0] w);
      logic signed [15:0] s;
      logic signed [63:0] r;
      s = w;
      r = s;
      return r;
   endfunction

   // Signed 64-bit division on magnitudes; the most negative quotient wraps.
   function automatic logic [63:0] quot64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] mn;
      logic [63:0] md;
      logic [63:0] q;
      mn = n[63] ? -n : n;
      md = d[63] ? -d : d;
      q  = mn / md;
      return (n[63] != d[63]) ? -q : q;
   endfunction

   // Compensation of one request; a temperature request updates the fine temperature.
   function automatic reading_type compensate(input logic op, input logic [19:0] raw);
      reading_type r;
      logic [31:0] t1, t2, t3, a, d, tv1, tv2;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, ft;
      r.kind = op;
      r.temperature_centi = '0;
      r.pressure_q24_8 = '0;
      r.div_zero = 1'b0;
      if (op == KIND_TEMP) begin
         t1 = {16'd0, cal_temp[15:0]};
         t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
         t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
         a = {15'd0, raw[19:3]} - (t1 << 1);
         tv1 = shr32(a * t2, 11);
         d = {16'd0, raw[19:4]} - t1;
         tv2 = shr32(shr32(d * d, 12) * t3, 14);
         fine_temp = tv1 + tv2;
         r.temperature_centi = shr32(fine_temp * 32'd5 + 32'd128, 8);
      end else begin
         p1 = {48'd0, cal_press_lo[15:0]};
         p2 = widen16(cal_press_lo[31:16]);
         p3 = widen16(cal_press_lo[47:32]);
         p4 = widen16(cal_press_lo[63:48]);
         p5 = widen16(cal_press_hi[15:0]);
         p6 = widen16(cal_press_hi[31:16]);
         p7 = widen16(cal_press_hi[47:32]);
         p8 = widen16(cal_press_hi[63:48]);
         p9 = widen16(cal_press_p9);
         ft = {{32{fine_temp[31]}}, fine_temp};
         v1 = ft - 64'd128000;
         v2 = v1 * v1 * p6;
         v2 = v2 + ((v1 * p5) << 17);
         v2 = v2 + (p4 << 35);
         v1 = shr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
         v1 = shr64((64'h0000_8000_0000_0000 + v1) * p1, 33);
         if (v1 == 64'd0) begin
            r.div_zero = 1'b1;
         end else begin
            p = 64'd1048576 - {44'd0, raw};
            p = ((p << 31) - v2) * 64'd3125;
            p = quot64(p, v1);
            v1 = shr64(p9 * shr64(p, 13) * shr64(p, 13), 25);
            v2 = shr64(p8 * p, 19);
            p = shr64(p + v1 + v2, 8) + (p7 << 4);
            r.pressure_q24_8 = p[31:0];
         end
      end
      return r;
   endfunction

   // One register write at the next edge; the caller lowers the write enable afterwards.
   task automatic write_cal(input logic [1:0] idx, input logic [63:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_TEMP_CAL:       cal_temp = data[47:0];
         CSR_PRESS_CAL_LOW:  cal_press_lo = data;
         CSR_PRESS_CAL_HIGH: cal_press_hi = data;
         default:            cal_press_p9 = data[15:0];
      endcase
   endtask

   // Wait until every expected result is back, then load a full calibration set.
   task automatic load_cal(input logic [63:0] tc, input logic [63:0] lo,
                           input logic [63:0] hi, input logic [63:0] p9);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_cal(CSR_TEMP_CAL, tc);
      write_cal(CSR_PRESS_CAL_LOW, lo);
      write_cal(CSR_PRESS_CAL_HIGH, hi);
      write_cal(CSR_PRESS_CAL_NINE, p9);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one request, hold it until accepted, then maybe idle for a while.
   task automatic send_request(input logic op, input logic [19:0] raw,
                               input logic typed, input reading_type want);
      reading_type got;
      int          gap;
      int          pick;
      req_valid <= 1'b1;
      req_op <= op;
      req_raw_sample <= raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = compensate(op, raw);
      pending_readings.push_back(typed ? want : got);
      pick = $urandom_range(99);
      if (pick < 65) gap = 0;
      else if (pick < 95) gap = $urandom_range(5, 1);
      else gap = $urandom_range(400, 20);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic void add_row(input logic op, input logic [19:0] raw, input logic typed,
                                   input logic [31:0] tc, input logic [31:0] pr,
                                   input logic dz);
      stim_row_type row;
      row.op = op;
      row.raw = raw;
      row.typed = typed;
      row.want.kind = op;
      row.want.temperature_centi = tc;
      row.want.pressure_q24_8 = pr;
      row.want.div_zero = dz;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Calibration words near typical sensor values, with random variation.
   function automatic logic [15:0] jitter(input int base, input int span);
      int v;
      v = base + $urandom_range(2 * span) - span;
      return v[15:0];
   endfunction

   // Receiver: random stalls, mostly short, plus one long hold-off on request.
   initial begin
      int stall;
      int pick;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req != 0) begin
            stall = 3000;
            long_hold_req = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            pick = $urandom_range(99);
            if (pick < 10) stall = $urandom_range(4, 1);
            else if (pick < 12) stall = $urandom_range(300, 40);
         end
      end
   end

   // Result checker: every accepted result against the oldest expectation.
   always @(posedge clock) begin
      reading_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected result kind %0d", $time, rsp_kind);
            errors++;
         end else begin
            w = pending_readings.pop_front();
            if (rsp_kind !== w.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, w.kind, rsp_kind);
               errors++;
            end
            if (rsp_temperature_centi !== w.temperature_centi) begin
               $display("%0t: temperature expected %0d actual %0d", $time,
                        $signed(w.temperature_centi), $signed(rsp_temperature_centi));
               errors++;
            end
            if (rsp_pressure_q24_8 !== w.pressure_q24_8) begin
               $display("%0t: pressure expected %h actual %h", $time,
                        w.pressure_q24_8, rsp_pressure_q24_8);
               errors++;
            end
            if (rsp_div_zero !== w.div_zero) begin
               $display("%0t: div_zero expected %0d actual %0d", $time,
                        w.div_zero, rsp_div_zero);
               errors++;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      reading_type none;
      int          phase;
      int          n;
      logic        op;
      logic [19:0] raw;
      none = '{kind: 1'b0, temperature_centi: '0, pressure_q24_8: '0, div_zero: 1'b0};
      errors = 0;
      long_hold_req = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = 1'b0;
      req_raw_sample = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cal_temp = '0;
      cal_press_lo = '0;
      cal_press_hi = '0;
      cal_press_p9 = '0;
      fine_temp = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With all calibration zero: temperature is zero and pressure hits the zero divisor,
      // including a pressure request before any temperature.
      add_row(KIND_PRESS, 20'd0, 1'b1, 32'd0, 32'd0, 1'b1);
      add_row(KIND_TEMP, 20'd0, 1'b1, 32'd0, 32'd0, 1'b0);
      add_row(KIND_TEMP, 20'hFFFFF, 1'b1, 32'd0, 32'd0, 1'b0);
      add_row(KIND_PRESS, 20'hFFFFF, 1'b1, 32'd0, 32'd0, 1'b1);
      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].raw, directed_rows[i].typed,
                      directed_rows[i].want);

      // Typical calibration: pressure with the stale fine temperature first.
      load_cal({16'hFC18, 16'd26435, 16'd27504},
               {16'd2855, 16'd3024, 16'hD643, 16'd36477},
               {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 64'd6000);
      send_request(KIND_PRESS, 20'd415148, 1'b0, none);
      send_request(KIND_TEMP, 20'd519888, 1'b0, none);
      send_request(KIND_PRESS, 20'd415148, 1'b0, none);
      send_request(KIND_TEMP, 20'd0, 1'b0, none);
      send_request(KIND_PRESS, 20'd0, 1'b0, none);
      send_request(KIND_TEMP, 20'hFFFFF, 1'b0, none);
      send_request(KIND_PRESS, 20'hFFFFF, 1'b0, none);

      // Every calibration bit set, with stray upper bits on the narrow registers.
      load_cal('1, '1, '1, '1);
      send_request(KIND_TEMP, 20'hFFFFF, 1'b0, none);
      send_request(KIND_PRESS, 20'hFFFFF, 1'b0, none);
      send_request(KIND_TEMP, 20'd0, 1'b0, none);
      send_request(KIND_PRESS, 20'd0, 1'b0, none);

      // Most positive and most negative words.
      load_cal({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
               {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 64'h8000);
      send_request(KIND_TEMP, 20'h80000, 1'b0, none);
      send_request(KIND_PRESS, 20'h7FFFF, 1'b0, none);
      load_cal({16'h7FFF, 16'h8000, 16'h0000}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001},
               {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 64'h7FFF);
      send_request(KIND_TEMP, 20'h12345, 1'b0, none);
      send_request(KIND_PRESS, 20'h54321, 1'b0, none);

      // P1 of zero forces the zero divisor whatever the temperature.
      load_cal({16'hFC18, 16'd26435, 16'd27504}, {16'd2855, 16'd3024, 16'hD643, 16'd0},
               rand64(), rand64());
      send_request(KIND_TEMP, 20'd519888, 1'b0, none);
      send_request(KIND_PRESS, 20'd415148, 1'b0, none);

      // Random phases: mostly realistic calibration, some fully random words.
      for (phase = 0; phase < 10; phase++) begin
         if (phase % 3 == 2)
            load_cal(rand64(), rand64(), rand64(), rand64());
         else
            load_cal({16'($urandom_range(65535)), jitter(-1000, 800), jitter(26435, 3000),
                      jitter(27504, 3000)},
                     {jitter(2855, 2000), jitter(3024, 2000), jitter(-10685, 3000),
                      jitter(36477, 4000)},
                     {jitter(-14600, 3000), jitter(15500, 3000), jitter(-7, 40),
                      jitter(140, 200)},
                     {$urandom(), $urandom_range(65535, 0)});
         if (phase == 1) long_hold_req = 1;
         for (n = 0; n < 123; n++) begin
            // Mostly temperature-then-pressure pairs; the rest are stray requests.
            if ($urandom_range(99) < 70) begin
               raw = ($urandom_range(1) == 1) ? 20'($urandom()) : 20'($urandom_range(600000, 300000));
               send_request(KIND_TEMP, raw, 1'b0, none);
               raw = ($urandom_range(1) == 1) ? 20'($urandom()) : 20'($urandom_range(500000, 250000));
               send_request(KIND_PRESS, raw, 1'b0, none);
               n++;
            end else begin
               op = 1'($urandom_range(1));
               send_request(op, 20'($urandom()), 1'b0, none);
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
